### rtl/lor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lor_pkg
// Types, constants and tables for the lidar occupancy grid rasterizer.
// ----------------------------------------------------------------------------
package lor_pkg;

   localparam int GRID_COLUMNS        = 200;
   localparam int GRID_ROWS           = 120;
   localparam int WALL_RADIUS_CELLS   = 4;
   localparam int OPPONENT_HALF_CELLS = 8;
   localparam int MAX_SAMPLES         = 4096;

   localparam int ROW_AW = $clog2(GRID_ROWS);

   localparam longint ANG_TWO_PI      = 105414357;
   localparam longint ANG_PI          = 52707179;
   localparam longint ANG_HALF_PI     = 26353589;
   localparam longint CORDIC_GAIN_Q30 = 652032874;
   localparam int     CORDIC_STEPS    = 24;
   localparam int     REDUCE_STEPS    = 7;
   localparam int     OCCUPIED        = 100;

   localparam int THETA_W = 35;
   localparam int Z_W     = 28;
   localparam int XY_W    = 34;
   localparam int PROD_W  = 51;
   localparam int SUM_W   = 52;
   localparam int DIV_W   = 22;
   localparam int POS_W   = 23;
   localparam int CSR_AW  = 5;

   typedef enum logic [1:0] {
      FN_CLEAR  = 2'd0,
      FN_SAMPLE = 2'd1,
      FN_OPP    = 2'd2,
      FN_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_REJECT = 2'd1,
      ST_OFF    = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_ANGLE_START = 3'd0,
      REG_ANGLE_STEP  = 3'd1,
      REG_RANGE_LIMIT = 3'd2,
      REG_RANGE_FLOOR = 3'd3,
      REG_SENSOR_X    = 3'd4,
      REG_X_ORIGIN    = 3'd5,
      REG_Y_ORIGIN    = 3'd6,
      REG_CELL_SIZE   = 3'd7
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRAP,
      S_REDUCE,
      S_FOLD,
      S_CORDIC,
      S_PROJ,
      S_SUM,
      S_DIV,
      S_QUOT,
      S_ROW,
      S_WR,
      S_RDOUT
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [11:0]        sample_index;
      logic [15:0]        range_mm;
      logic               range_finite;
      logic signed [15:0] opponent_x_mm;
      logic signed [15:0] opponent_y_mm;
      logic [7:0]         read_column;
      logic [6:0]         read_row;
   } req_type;

   typedef struct packed {
      logic [6:0] cell_value;
      logic [1:0] status;
   } rsp_type;

   function automatic longint cordic_atan(input int i);
      longint t;
      begin
         case (i)
            0:       t = 13176795;
            1:       t = 7778716;
            2:       t = 4110060;
            3:       t = 2086331;
            4:       t = 1047214;
            5:       t = 524117;
            6:       t = 262123;
            7:       t = 131069;
            default: t = longint'(1) << (24 - i);
         endcase
         return t;
      end
   endfunction

   function automatic int disc_half(input int d);
      int w;
      begin
         w = 0;
         for (int k = 0; k <= WALL_RADIUS_CELLS; k++) begin
            if (k * k + d * d <= WALL_RADIUS_CELLS * WALL_RADIUS_CELLS) w = k;
         end
         return w;
      end
   endfunction

endpackage
`default_nettype wire

### rtl/lidar_occupancy_grid_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_occupancy_grid_rasterizer
// One-bit occupancy grid kept as one RAM word per row; samples go through
// angle reduction, a 24-step cordic and a 22-step divider, then each stencil
// row is read, or-ed with its mask and written back.
// flow: clear, rejects and off-grid reads answer straight from idle, a read
//   answers from S_RDOUT, an opponent runs the divider and its stencil rows,
//   a sample runs cordic, divider and a read and a write state per stencil row
// throughput: one item at a time, next start once busy is low
// reset: config registers to defaults, row valid bits cleared, grid reads free
// ----------------------------------------------------------------------------
module lidar_occupancy_grid_rasterizer
   import lor_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   state_type state_ff, state_in;

   logic signed [26:0] angle_start_ff;
   logic [20:0]        angle_step_ff;
   logic [15:0]        range_limit_ff, range_floor_ff;
   logic signed [15:0] sensor_x_ff, x_origin_ff, y_origin_ff;
   logic [9:0]         cell_size_ff;

   logic signed [THETA_W-1:0] theta_ff, theta_in;
   logic [2:0]                k_ff, k_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic signed [XY_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic                      neg_ff, neg_in;
   logic [4:0]                i_ff, i_in;
   logic [15:0]               r_ff, r_in;
   logic signed [PROD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [DIV_W-1:0]          nx_ff, nx_in, ny_ff, ny_in;
   logic [9:0]                rx_ff, rx_in, ry_ff, ry_in;
   logic                      sx_ff, sx_in, sy_ff, sy_in;
   logic                      smp_ff, smp_in;
   logic signed [POS_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic signed [5:0]         dy_ff, dy_in;
   logic [GRID_ROWS-1:0]      valid_ff, valid_in;
   logic [ROW_AW-1:0]         rrow_ff, rrow_in;
   logic [7:0]                rcol_ff, rcol_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                    ram_we;
   logic [ROW_AW-1:0]       ram_waddr, ram_raddr;
   logic [GRID_COLUMNS-1:0] ram_wdata, ram_rdata, mask;

   lor_ram #(.WIDTH(GRID_COLUMNS), .DEPTH(GRID_ROWS)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // configuration port
   logic    csr_wr;
   reg_type csr_idx;
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = reg_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= -27'sd39530384;
         angle_step_ff  <= 21'd97612;
         range_limit_ff <= 16'd30000;
         range_floor_ff <= 16'd50;
         sensor_x_ff    <= 16'sd210;
         x_origin_ff    <= -16'sd1000;
         y_origin_ff    <= -16'sd3000;
         cell_size_ff   <= 10'd50;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ANGLE_START: angle_start_ff <= pwdata[26:0];
            REG_ANGLE_STEP:  angle_step_ff  <= pwdata[20:0];
            REG_RANGE_LIMIT: range_limit_ff <= pwdata[15:0];
            REG_RANGE_FLOOR: range_floor_ff <= pwdata[15:0];
            REG_SENSOR_X:    sensor_x_ff    <= pwdata[15:0];
            REG_X_ORIGIN:    x_origin_ff    <= pwdata[15:0];
            REG_Y_ORIGIN:    y_origin_ff    <= pwdata[15:0];
            REG_CELL_SIZE:   cell_size_ff   <= pwdata[9:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_type'(paddr[4:2]))
         REG_ANGLE_START: prdata = {5'd0, angle_start_ff};
         REG_ANGLE_STEP:  prdata = {11'd0, angle_step_ff};
         REG_RANGE_LIMIT: prdata = {16'd0, range_limit_ff};
         REG_RANGE_FLOOR: prdata = {16'd0, range_floor_ff};
         REG_SENSOR_X:    prdata = {16'd0, sensor_x_ff};
         REG_X_ORIGIN:    prdata = {16'd0, x_origin_ff};
         REG_Y_ORIGIN:    prdata = {16'd0, y_origin_ff};
         REG_CELL_SIZE:   prdata = {22'd0, cell_size_ff};
      endcase
   end

   // shared helpers
   logic [9:0]              divisor;
   logic [5:0]              half;
   logic signed [POS_W-1:0] row_tgt;
   logic                    tgt_in_grid;
   logic [4:0]              dy_abs;
   logic [4:0]              w_cur;
   logic signed [POS_W-1:0] lo_col, hi_col;

   assign divisor     = (cell_size_ff == 10'd0) ? 10'd1 : cell_size_ff;
   assign half        = smp_ff ? 6'(WALL_RADIUS_CELLS) : 6'(OPPONENT_HALF_CELLS);
   assign row_tgt     = row_ff + POS_W'(dy_ff);
   assign tgt_in_grid = (row_tgt >= 0) && (row_tgt < POS_W'(GRID_ROWS));
   assign dy_abs      = dy_ff[5] ? 5'(-dy_ff) : dy_ff[4:0];
   assign w_cur       = smp_ff ? 5'(disc_half(int'(dy_abs))) : 5'(OPPONENT_HALF_CELLS);
   assign lo_col      = col_ff - POS_W'(w_cur);
   assign hi_col      = col_ff + POS_W'(w_cur);

   always_comb begin
      for (int j = 0; j < GRID_COLUMNS; j++) begin
         mask[j] = (POS_W'(j) >= lo_col) && (POS_W'(j) <= hi_col);
      end
   end

   // datapath scratch
   logic [32:0]               idx_prod;
   logic signed [THETA_W-1:0] red_const, zf1, zf2;
   logic signed [XY_W-1:0]    dxs, dys, c_val, s_val;
   logic signed [Z_W-1:0]     atan_v;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [DIV_W-1:0]   qx, qy;
   logic [10:0]               rsx, rsy;
   logic                      bx, by;
   logic signed [16:0]        dox, doy;
   logic                      fold_neg;
   logic                      reject;

   always_comb begin
      state_in     = state_ff;
      theta_in     = theta_ff;
      k_in         = k_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      i_in         = i_ff;
      r_in         = r_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      smp_in       = smp_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dy_in        = dy_ff;
      valid_in     = valid_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = row_tgt[ROW_AW-1:0];
      ram_wdata    = (valid_ff[row_tgt[ROW_AW-1:0]] ? ram_rdata : '0) | mask;
      ram_raddr    = row_tgt[ROW_AW-1:0];

      idx_prod  = 33'(req_data.sample_index) * 33'(angle_step_ff);
      red_const = THETA_W'(ANG_TWO_PI) <<< k_ff;
      zf1       = (theta_ff > THETA_W'(ANG_PI)) ? theta_ff - THETA_W'(ANG_TWO_PI) : theta_ff;
      zf2       = zf1;
      fold_neg  = 1'b0;
      if (zf1 > THETA_W'(ANG_HALF_PI)) begin
         zf2      = zf1 - THETA_W'(ANG_PI);
         fold_neg = 1'b1;
      end else if (zf1 < -THETA_W'(ANG_HALF_PI)) begin
         zf2      = zf1 + THETA_W'(ANG_PI);
         fold_neg = 1'b1;
      end
      dxs    = y_ff >>> i_ff;
      dys    = x_ff >>> i_ff;
      atan_v = Z_W'(cordic_atan(int'(i_ff)));
      c_val  = neg_ff ? -x_ff : x_ff;
      s_val  = neg_ff ? -y_ff : y_ff;
      sum_x  = (SUM_W'(17'(sensor_x_ff) - 17'(x_origin_ff)) <<< 30) + SUM_W'(px_ff);
      sum_y  = (SUM_W'(-17'(y_origin_ff)) <<< 30) + SUM_W'(py_ff);
      qx     = sum_x[SUM_W-1:30];
      qy     = sum_y[SUM_W-1:30];
      rsx    = {rx_ff, nx_ff[DIV_W-1]};
      rsy    = {ry_ff, ny_ff[DIV_W-1]};
      bx     = rsx >= {1'b0, divisor};
      by     = rsy >= {1'b0, divisor};
      dox    = 17'(req_data.opponent_x_mm) - 17'(x_origin_ff);
      doy    = 17'(req_data.opponent_y_mm) - 17'(y_origin_ff);
      reject = !req_data.range_finite || (req_data.range_mm < range_floor_ff) ||
               (req_data.range_mm > range_limit_ff) ||
               (17'(req_data.sample_index) >= 17'(MAX_SAMPLES));

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (func_type'(req_data.func))
                  FN_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{cell_value: 7'd0, status: ST_DONE};
                  end
                  FN_SAMPLE: begin
                     if (reject) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{cell_value: 7'd0, status: ST_REJECT};
                     end else begin
                        theta_in = THETA_W'(angle_start_ff) + THETA_W'({1'b0, idx_prod});
                        r_in     = req_data.range_mm;
                        smp_in   = 1'b1;
                        state_in = S_WRAP;
                     end
                  end
                  FN_OPP: begin
                     if (req_data.opponent_x_mm <= 0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{cell_value: 7'd0, status: ST_ABSENT};
                     end else begin
                        smp_in   = 1'b0;
                        sx_in    = dox[16];
                        sy_in    = doy[16];
                        nx_in    = dox[16] ? DIV_W'(-dox) : DIV_W'(dox);
                        ny_in    = doy[16] ? DIV_W'(-doy) : DIV_W'(doy);
                        rx_in    = '0;
                        ry_in    = '0;
                        i_in     = '0;
                        state_in = S_DIV;
                     end
                  end
                  FN_READ: begin
                     if ((16'(req_data.read_column) < 16'(GRID_COLUMNS)) &&
                         (16'(req_data.read_row) < 16'(GRID_ROWS))) begin
                        ram_raddr = ROW_AW'(req_data.read_row);
                        rrow_in   = ROW_AW'(req_data.read_row);
                        rcol_in   = req_data.read_column;
                        state_in  = S_RDOUT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{cell_value: 7'd0, status: ST_OFF};
                     end
                  end
               endcase
            end
         end
         S_WRAP: begin
            if (theta_ff < 0) theta_in = theta_ff + THETA_W'(ANG_TWO_PI);
            k_in     = 3'(REDUCE_STEPS - 1);
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (theta_ff >= red_const) theta_in = theta_ff - red_const;
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) state_in = S_FOLD;
         end
         S_FOLD: begin
            z_in     = Z_W'(zf2);
            neg_in   = fold_neg;
            x_in     = XY_W'(CORDIC_GAIN_Q30);
            y_in     = '0;
            i_in     = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dxs;
               y_in = y_ff + dys;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + dxs;
               y_in = y_ff - dys;
               z_in = z_ff + atan_v;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(CORDIC_STEPS - 1)) state_in = S_PROJ;
         end
         S_PROJ: begin
            px_in    = PROD_W'($signed({1'b0, r_ff})) * PROD_W'(c_val);
            py_in    = PROD_W'($signed({1'b0, r_ff})) * PROD_W'(s_val);
            state_in = S_SUM;
         end
         S_SUM: begin
            sx_in    = qx[DIV_W-1];
            sy_in    = qy[DIV_W-1];
            nx_in    = qx[DIV_W-1] ? DIV_W'(-qx) : DIV_W'(qx);
            ny_in    = qy[DIV_W-1] ? DIV_W'(-qy) : DIV_W'(qy);
            rx_in    = '0;
            ry_in    = '0;
            i_in     = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rx_in = bx ? 10'(rsx - {1'b0, divisor}) : rsx[9:0];
            ry_in = by ? 10'(rsy - {1'b0, divisor}) : rsy[9:0];
            nx_in = {nx_ff[DIV_W-2:0], bx};
            ny_in = {ny_ff[DIV_W-2:0], by};
            i_in  = i_ff + 5'd1;
            if (i_ff == 5'(DIV_W - 1)) state_in = S_QUOT;
         end
         S_QUOT: begin
            col_in = sx_ff ? -(POS_W'(nx_ff) + POS_W'(rx_ff != 10'd0)) : POS_W'(nx_ff);
            row_in = sy_ff ? -(POS_W'(ny_ff) + POS_W'(ry_ff != 10'd0)) : POS_W'(ny_ff);
            if (smp_ff && (sx_ff || sy_ff || (POS_W'(nx_ff) >= POS_W'(GRID_COLUMNS)) ||
                           (POS_W'(ny_ff) >= POS_W'(GRID_ROWS)))) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{cell_value: 7'd0, status: ST_OFF};
               state_in     = S_IDLE;
            end else begin
               dy_in    = -$signed(half);
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (tgt_in_grid) begin
               state_in = S_WR;
            end else if (dy_ff == $signed(half)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{cell_value: 7'd0, status: ST_DONE};
               state_in     = S_IDLE;
            end else begin
               dy_in = dy_ff + 6'sd1;
            end
         end
         S_WR: begin
            ram_we                          = 1'b1;
            valid_in[row_tgt[ROW_AW-1:0]]   = 1'b1;
            if (dy_ff == $signed(half)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{cell_value: 7'd0, status: ST_DONE};
               state_in     = S_IDLE;
            end else begin
               dy_in    = dy_ff + 6'sd1;
               state_in = S_ROW;
            end
         end
         S_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{cell_value: (valid_ff[rrow_ff] && ram_rdata[rcol_ff])
                                         ? 7'(OCCUPIED) : 7'd0,
                             status: ST_DONE};
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      theta_ff <= theta_in;
      k_ff     <= k_in;
      z_ff     <= z_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      i_ff     <= i_in;
      r_ff     <= r_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      smp_ff   <= smp_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      dy_ff    <= dy_in;
      rrow_ff  <= rrow_in;
      rcol_ff  <= rcol_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_value_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_DONE) |-> (rsp_data.cell_value == 7'd0))
      else $error("cell value on a failed item");

   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> tgt_in_grid)
      else $error("row write outside grid");

   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> ($past(state_ff) == S_ROW))
      else $error("row write without its read");
`endif

endmodule
`default_nettype wire

### rtl/lor_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lor_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lor_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire
